@@ rtl/alist_pkg.sv @@
// Shared constants, codes and interface types for the array list block.
`timescale 1ns / 1ps

package alist_pkg;

   localparam int DEPTH   = 16;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int FILL_W  = $clog2(DEPTH + 1);
   localparam int FUNC_W  = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;
   localparam int CMP_W   = (FILL_W > POS_W) ? FILL_W : POS_W;
   localparam int REQ_W   = ((FUNC_W + VALUE_W + POS_W + 7) / 8) * 8;
   localparam int RSP_W   = ((2 + VALUE_W + COUNT_W + 7) / 8) * 8;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_FRONT = 3'd0,
      FN_PUSH_BACK  = 3'd1,
      FN_POP_FRONT  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_INSERT     = 3'd4,
      FN_DELETE     = 3'd5,
      FN_DUMP       = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [VALUE_W-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic               load;
      status_type         status;
      logic [VALUE_W-1:0] element;
      logic [COUNT_W-1:0] count;
      logic               last;
   } result_type;

endpackage

@@ rtl/alist_mem.sv @@
// Element storage: one write port and one registered read port.
`timescale 1ns / 1ps

module alist_mem (
   input  logic                          clock,
   input  alist_pkg::mem_req_type        mem_req,
   output logic [alist_pkg::VALUE_W-1:0] rd_data
);

   logic [alist_pkg::VALUE_W-1:0] slots_ff [alist_pkg::DEPTH];
   logic [alist_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slots_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= slots_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/alist_ctrl.sv @@
// Sequencer: decodes a request, shifts stored entries one per cycle, builds results.
`timescale 1ns / 1ps

module alist_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [alist_pkg::FUNC_W-1:0]  req_func,
   input  logic [alist_pkg::VALUE_W-1:0] req_value,
   input  logic [alist_pkg::POS_W-1:0]   req_position,
   input  logic                          out_free,
   input  logic [alist_pkg::VALUE_W-1:0] rd_data,
   output alist_pkg::mem_req_type        mem_req,
   output alist_pkg::result_type         result
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_UP    = 6'b000010,
      S_DOWN  = 6'b000100,
      S_DREAD = 6'b001000,
      S_DWAIT = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   logic [alist_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [alist_pkg::FILL_W-1:0]  idx_ff, idx_in;
   logic [alist_pkg::FILL_W-1:0]  at_ff, at_in;
   logic [alist_pkg::FILL_W-1:0]  wa_ff, wa_in;
   logic                          pend_ff, pend_in;
   logic [alist_pkg::VALUE_W-1:0] val_ff, val_in;
   alist_pkg::status_type         st_ff, st_in;

   logic                          full;
   logic                          empty;
   logic [alist_pkg::CMP_W-1:0]   pos_ext;
   logic [alist_pkg::CMP_W-1:0]   fill_ext;
   logic [alist_pkg::FILL_W-1:0]  idx_inc;
   logic [alist_pkg::FILL_W-1:0]  idx_dec;

   assign full     = (fill_ff >= alist_pkg::FILL_W'(alist_pkg::DEPTH));
   assign empty    = (fill_ff == '0);
   assign pos_ext  = alist_pkg::CMP_W'(req_position);
   assign fill_ext = alist_pkg::CMP_W'(fill_ff);
   assign idx_inc  = idx_ff + alist_pkg::FILL_W'(1);
   assign idx_dec  = idx_ff - alist_pkg::FILL_W'(1);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      at_in    = at_ff;
      wa_in    = wa_ff;
      pend_in  = pend_ff;
      val_in   = val_ff;
      st_in    = st_ff;
      mem_req  = '0;
      result   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in  = req_value;
               st_in   = alist_pkg::ST_OK;
               pend_in = 1'b0;
               case (req_func)
                  alist_pkg::FN_PUSH_FRONT: begin
                     if (full) begin
                        st_in    = alist_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        at_in    = '0;
                        idx_in   = fill_ff;
                        state_in = S_UP;
                     end
                  end
                  alist_pkg::FN_PUSH_BACK: begin
                     if (full) begin
                        st_in    = alist_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        at_in    = fill_ff;
                        idx_in   = fill_ff;
                        state_in = S_UP;
                     end
                  end
                  alist_pkg::FN_POP_FRONT: begin
                     if (empty) begin
                        st_in    = alist_pkg::ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        idx_in   = '0;
                        state_in = S_DOWN;
                     end
                  end
                  alist_pkg::FN_POP_BACK: begin
                     if (empty) begin
                        st_in = alist_pkg::ST_EMPTY;
                     end else begin
                        fill_in = fill_ff - alist_pkg::FILL_W'(1);
                     end
                     state_in = S_RESP;
                  end
                  alist_pkg::FN_INSERT: begin
                     if (full) begin
                        st_in    = alist_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else if (pos_ext > fill_ext) begin
                        st_in    = alist_pkg::ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        at_in    = alist_pkg::FILL_W'(req_position);
                        idx_in   = fill_ff;
                        state_in = S_UP;
                     end
                  end
                  alist_pkg::FN_DELETE: begin
                     if (empty) begin
                        st_in    = alist_pkg::ST_EMPTY;
                        state_in = S_RESP;
                     end else if (pos_ext >= fill_ext) begin
                        st_in    = alist_pkg::ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        idx_in   = alist_pkg::FILL_W'(req_position);
                        state_in = S_DOWN;
                     end
                  end
                  alist_pkg::FN_DUMP: begin
                     if (empty) begin
                        st_in    = alist_pkg::ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        idx_in   = '0;
                        state_in = S_DREAD;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_UP: begin
            // write back the entry read last cycle one place higher
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = wa_ff[alist_pkg::ADDR_W-1:0];
               mem_req.wr_data = rd_data;
               pend_in         = 1'b0;
            end
            if (idx_ff > at_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_dec[alist_pkg::ADDR_W-1:0];
               wa_in           = idx_ff;
               idx_in          = idx_dec;
               pend_in         = 1'b1;
            end else if (!pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = at_ff[alist_pkg::ADDR_W-1:0];
               mem_req.wr_data = val_ff;
               fill_in         = fill_ff + alist_pkg::FILL_W'(1);
               state_in        = S_RESP;
            end
         end

         S_DOWN: begin
            // write back the entry read last cycle one place lower
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = wa_ff[alist_pkg::ADDR_W-1:0];
               mem_req.wr_data = rd_data;
               pend_in         = 1'b0;
            end
            if (idx_inc < fill_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_inc[alist_pkg::ADDR_W-1:0];
               wa_in           = idx_ff;
               idx_in          = idx_inc;
               pend_in         = 1'b1;
            end else if (!pend_ff) begin
               fill_in  = fill_ff - alist_pkg::FILL_W'(1);
               state_in = S_RESP;
            end
         end

         S_DREAD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff[alist_pkg::ADDR_W-1:0];
            state_in        = S_DWAIT;
         end

         S_DWAIT: begin
            // hold the read data until the output register frees up
            if (out_free) begin
               result.load    = 1'b1;
               result.status  = alist_pkg::ST_OK;
               result.element = rd_data;
               result.count   = alist_pkg::COUNT_W'(fill_ff);
               result.last    = (idx_inc == fill_ff);
               if (idx_inc == fill_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_DREAD;
               end
            end
         end

         S_RESP: begin
            if (out_free) begin
               result.load    = 1'b1;
               result.status  = st_ff;
               result.element = '0;
               result.count   = alist_pkg::COUNT_W'(fill_ff);
               result.last    = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      at_ff  <= at_in;
      wa_ff  <= wa_in;
      val_ff <= val_in;
      st_ff  <= st_in;
   end

endmodule

@@ rtl/array_list_insert_delete.sv @@
// Top level of the array list: stream ports, sequencer, storage and result register.
// Pop back, rejected and unused requests go straight to the response state; push, pop
//   front, insert and delete first pass through the move state (S_UP or S_DOWN), then respond.
// Throughput: one request at a time; a dump reads each element (S_DREAD) and then sends it
//   (S_DWAIT), holding it there while the result register is not free.
// Reset clears the count and the sequencer; storage is not cleared (no clearing pass).
`timescale 1ns / 1ps

module array_list_insert_delete (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [alist_pkg::REQ_W-1:0] req_tdata,  // func[2:0], value[34:3], position[39:35]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [alist_pkg::RSP_W-1:0] rsp_tdata,  // status[1:0], element[33:2], count[38:34]
   output logic                        rsp_tlast
);

   localparam int ST_LO  = 0;
   localparam int EL_LO  = 2;
   localparam int CNT_LO = EL_LO + alist_pkg::VALUE_W;
   localparam int PAD_W  = alist_pkg::RSP_W - CNT_LO - alist_pkg::COUNT_W;

   alist_pkg::mem_req_type        mem_req;
   alist_pkg::result_type         result;
   logic [alist_pkg::VALUE_W-1:0] rd_data;
   logic                          out_free;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [alist_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [alist_pkg::FUNC_W-1:0]  req_func;
   logic [alist_pkg::VALUE_W-1:0] req_value;
   logic [alist_pkg::POS_W-1:0]   req_position;

   assign req_func     = req_tdata[alist_pkg::FUNC_W-1:0];
   assign req_value    = req_tdata[alist_pkg::FUNC_W +: alist_pkg::VALUE_W];
   assign req_position = req_tdata[alist_pkg::FUNC_W + alist_pkg::VALUE_W +: alist_pkg::POS_W];

   assign out_free = !rsp_valid_ff || rsp_tready;

   alist_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_func     (req_func),
      .req_value    (req_value),
      .req_position (req_position),
      .out_free     (out_free),
      .rd_data      (rd_data),
      .mem_req      (mem_req),
      .result       (result)
   );

   alist_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (result.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{PAD_W{1'b0}}, result.count, result.element, result.status};
         rsp_last_in  = result.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // an accepted request always leaves the sequencer busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted back to back");

   // any non-ok status ends its request
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[EL_LO-1:ST_LO] != alist_pkg::ST_OK)) |-> rsp_tlast)
      else $error("error result not marked last");

   // only dump results carry an element, and those are ok
   a_element_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[CNT_LO-1:EL_LO] != '0))
         |-> (rsp_tdata[EL_LO-1:ST_LO] == alist_pkg::ST_OK))
      else $error("element returned with error status");

   // a dump run that continues needs a nonempty list
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[CNT_LO +: alist_pkg::COUNT_W] != '0))
      else $error("multi-item run from an empty list");

endmodule
